FILE: design/tgg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgg_pkg - shared types, constants and functions of the tripod gait generator
// Holds the quarter-wave sine ROM, fixed-point helpers and the register set.
// ----------------------------------------------------------------------------
package tgg_pkg;

  localparam int LEG_COUNT  = 6;
  localparam int SINE_DEPTH = 256;
  localparam int TIME_BITS  = 32;

  localparam int SD_BITS   = $clog2(SINE_DEPTH);
  localparam int PH_BITS   = SD_BITS + 2;
  localparam int LEG_W     = 3;
  localparam int Q14_ONE   = 16384;
  localparam int DECAY_Q16 = 62259;

  // register indexes
  localparam logic [2:0] REG_HOME_X      = 3'd0;
  localparam logic [2:0] REG_HOME_Y      = 3'd1;
  localparam logic [2:0] REG_HOME_Z      = 3'd2;
  localparam logic [2:0] REG_STEP_HEIGHT = 3'd3;
  localparam logic [2:0] REG_STEP_LENGTH = 3'd4;
  localparam logic [2:0] REG_CYCLE_TIME  = 3'd5;

  // reset values
  localparam logic signed [15:0] RST_HOME_X      = 16'sd0;
  localparam logic signed [15:0] RST_HOME_Y      = 16'sd1600;
  localparam logic signed [15:0] RST_HOME_Z      = -16'sd1280;
  localparam logic [14:0]        RST_STEP_HEIGHT = 15'd480;
  localparam logic [14:0]        RST_STEP_LENGTH = 15'd640;
  localparam logic [15:0]        RST_CYCLE_TIME  = 16'd1000;

  typedef struct packed {
    logic signed [15:0] home_x;
    logic signed [15:0] home_y;
    logic signed [15:0] home_z;
    logic [14:0]        step_height;
    logic [14:0]        step_length;
    logic [15:0]        cycle_time;
  } cfg_t;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH+1];

  // quarter-wave table, worked out at elaboration
  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    longint x, x2, p, s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      if (k == 0) begin
        r[k] = 15'd0;
      end else if (k >= SINE_DEPTH) begin
        r[k] = 15'(Q14_ONE);
      end else begin
        x  = (longint'(k) * 65536) / SINE_DEPTH;
        x2 = (x * x) >>> 16;
        p  = 11;
        p  = 307 - ((x2 * p) >>> 16);
        p  = 5223 - ((x2 * p) >>> 16);
        p  = 42334 - ((x2 * p) >>> 16);
        p  = 102944 - ((x2 * p) >>> 16);
        s  = (((x * p) >>> 16) + 2) >>> 2;
        if (s > Q14_ONE) s = Q14_ONE;
        r[k] = 15'(s);
      end
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // full-wave sine, Q1.14
  function automatic logic signed [15:0] wave_sine(input logic [PH_BITS-1:0] a);
    logic [SD_BITS-1:0] k;
    logic [SD_BITS:0]   idx;
    logic [14:0]        m;
    logic               neg;
    k   = a[SD_BITS-1:0];
    idx = {1'b0, k};
    neg = a[PH_BITS-1];
    if (a[PH_BITS-2]) idx = (SD_BITS+1)'(SINE_DEPTH) - {1'b0, k};
    m = SINE_ROM[idx];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_move(input logic signed [15:0] v);
    if (v > 16'sd16384) return 16'sd16384;
    if (v < -16'sd16384) return -16'sd16384;
    return v;
  endfunction

endpackage

FILE: design/tgg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgg_cfg - configuration registers
// APB-style write/read of the six gait registers.
// ----------------------------------------------------------------------------
module tgg_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output tgg_pkg::cfg_t cfg_o
);
  import tgg_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_x      <= RST_HOME_X;
      cfg_q.home_y      <= RST_HOME_Y;
      cfg_q.home_z      <= RST_HOME_Z;
      cfg_q.step_height <= RST_STEP_HEIGHT;
      cfg_q.step_length <= RST_STEP_LENGTH;
      cfg_q.cycle_time  <= RST_CYCLE_TIME;
    end else if (wr) begin
      case (idx)
        REG_HOME_X:      cfg_q.home_x      <= pwdata[15:0];
        REG_HOME_Y:      cfg_q.home_y      <= pwdata[15:0];
        REG_HOME_Z:      cfg_q.home_z      <= pwdata[15:0];
        REG_STEP_HEIGHT: cfg_q.step_height <= pwdata[14:0];
        REG_STEP_LENGTH: cfg_q.step_length <= pwdata[14:0];
        REG_CYCLE_TIME:  cfg_q.cycle_time  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_HOME_X:      prdata = {16'd0, cfg_q.home_x};
      REG_HOME_Y:      prdata = {16'd0, cfg_q.home_y};
      REG_HOME_Z:      prdata = {16'd0, cfg_q.home_z};
      REG_STEP_HEIGHT: prdata = {17'd0, cfg_q.step_height};
      REG_STEP_LENGTH: prdata = {17'd0, cfg_q.step_length};
      REG_CYCLE_TIME:  prdata = {16'd0, cfg_q.cycle_time};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/tgg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgg_div - serial phase divider
// Long division of elapsed time by the cycle, continued over PH_BITS zero
// bits, so the last quotient bits give (elapsed mod cyc) * turn / cyc.
// ----------------------------------------------------------------------------
module tgg_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tgg_pkg::TIME_BITS-1:0]   dividend_i,
  input  logic [15:0]                     divisor_i,
  output logic                            done_o,
  output logic [tgg_pkg::PH_BITS-1:0]     phase_o
);
  import tgg_pkg::*;

  localparam int STEPS  = TIME_BITS + PH_BITS;
  localparam int CNT_W  = $clog2(STEPS + 1);

  logic                 busy_q, busy_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [15:0]          rem_q, rem_d;
  logic [TIME_BITS-1:0] sh_q, sh_d;
  logic [PH_BITS-1:0]   quo_q, quo_d;
  logic [15:0]          dvs_q, dvs_d;
  logic                 done_q, done_d;
  logic [16:0]          trial;
  logic                 ge;

  assign trial   = {rem_q, sh_q[TIME_BITS-1]};
  assign ge      = trial >= {1'b0, dvs_q};
  assign done_o  = done_q;
  assign phase_o = quo_q;

  // one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      sh_d   = dividend_i;
      quo_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      sh_d  = {sh_q[TIME_BITS-2:0], 1'b0};
      quo_d = {quo_q[PH_BITS-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  // done is never seen while busy, start leads to busy, and the count stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   busy_q |-> cnt_q < CNT_W'(STEPS))
    else $error("divider count overrun");

endmodule

FILE: design/tripod_gait_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tripod_gait_generator_top - tripod gait target generator
// Turns tick items (time, move command) into six leg targets per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one tick item: now_ms and the
//   move command. A non-zero command starts the gait, all zero stops it.
//   Output channel (out_valid_o/out_ready_i) gives LEG_COUNT items per tick,
//   leg 0 first, last_leg set on the final one.
//   Walking tick: the serial divider works out 42 quotient bits, one per
//   cycle, then the shared multiplier steps run for each leg in turn, then
//   emission.
//   Stopped tick: the divider is skipped and the multiplier steps run for
//   each leg. One shared 30x18 multiplier sets the per-leg cost.
//   Emission gives one leg per cycle while the receiver does not stall.
//   in_ready_o is high only while the block is idle.
//   A stalled receiver holds the output register; emission waits on it.
//   Reset: gait stopped, targets at the reset home position, registers at
//   their reset values. Configuration is written through the APB port.
// ----------------------------------------------------------------------------
module tripod_gait_generator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        now_ms_i,
  input  logic signed [15:0] move_x_i,
  input  logic signed [15:0] move_y_i,
  input  logic signed [15:0] move_yaw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         leg_index_o,
  output logic signed [15:0] target_x_o,
  output logic signed [15:0] target_y_o,
  output logic signed [15:0] target_z_o,
  output logic               walking_o,
  output logic               last_leg_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tgg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  localparam logic signed [47:0] HALF28 = 48'sd134217728;
  localparam logic signed [47:0] HALF14 = 48'sd8192;

  cfg_t cfg;

  state_e               state_q, state_d;
  logic                 running_q, running_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic signed [15:0]   mx_q, my_q;
  logic [PH_BITS-1:0]   phase_q;
  logic [LEG_W-1:0]     leg_q, leg_d;
  logic [2:0]           st_q, st_d;
  logic signed [47:0]   prod_q, prod_d;
  logic                 neg_q, neg_d;

  logic signed [15:0] tx_q [LEG_COUNT];
  logic signed [15:0] ty_q [LEG_COUNT];
  logic signed [15:0] tz_q [LEG_COUNT];

  logic               ov_q, ov_d;
  logic [LEG_W-1:0]   oleg_q;
  logic signed [15:0] ox_q, oy_q, oz_q;
  logic               owalk_q;
  logic               load;

  logic               accept, nonzero, div_start, div_done;
  logic [TIME_BITS-1:0] elapsed;
  logic [15:0]        cyc;
  logic [PH_BITS-1:0] div_phase, aph;
  logic signed [15:0] sn, cs;
  logic signed [29:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [16:0] diff;
  logic signed [17:0] mag;
  logic signed [47:0] rnd28, lift, dec;
  logic               wr_x, wr_y, wr_z, last_step;
  logic signed [15:0] nx, ny, nz;

  tgg_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  tgg_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (elapsed),
    .divisor_i  (cyc),
    .done_o     (div_done),
    .phase_o    (div_phase)
  );

  // tick decode
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign nonzero    = (move_x_i != 16'sd0) | (move_y_i != 16'sd0) | (move_yaw_i != 16'sd0);
  assign running_d  = accept ? nonzero : running_q;
  assign start_d    = (accept & nonzero & !running_q) ? now_ms_i[TIME_BITS-1:0] : start_q;
  assign elapsed    = now_ms_i[TIME_BITS-1:0] - start_d;
  assign cyc        = (cfg.cycle_time == 16'd0) ? 16'd1 : cfg.cycle_time;
  assign div_start  = accept & nonzero;

  // leg phase and sine lookups
  assign aph = leg_q[0] ? PH_BITS'(phase_q + PH_BITS'(2 * SINE_DEPTH)) : phase_q;
  assign sn  = wave_sine(aph);
  assign cs  = wave_sine(PH_BITS'(aph + PH_BITS'(SINE_DEPTH)));

  // result shaping from the last product
  assign rnd28 = (prod_q + HALF28) >>> 28;
  assign lift  = aph[PH_BITS-1] ? 48'sd0 : ((prod_q + HALF14) >>> 14);
  assign dec   = neg_q ? -(prod_q >>> 16) : (prod_q >>> 16);

  // operand select and write-back per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg_d = neg_q;
    diff  = '0;
    mag   = '0;
    wr_x  = 1'b0;
    wr_y  = 1'b0;
    wr_z  = 1'b0;
    nx    = '0;
    ny    = '0;
    nz    = '0;
    last_step = 1'b0;
    if (running_q) begin
      case (st_q)
        3'd0: begin
          mul_a = 30'(mx_q);
          mul_b = 18'(cs);
        end
        3'd1, 3'd3: begin
          mul_a = prod_q[29:0];
          mul_b = $signed({3'b000, cfg.step_length});
        end
        3'd2: begin
          wr_x  = 1'b1;
          nx    = sat16(-rnd28);
          mul_a = 30'(my_q);
          mul_b = 18'(cs);
        end
        3'd4: begin
          wr_y  = 1'b1;
          ny    = sat16(48'(cfg.home_y) - rnd28);
          mul_a = $signed({15'd0, cfg.step_height});
          mul_b = 18'(sn);
        end
        3'd5: begin
          wr_z = 1'b1;
          nz   = sat16(48'(cfg.home_z) + lift);
          last_step = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (st_q)
        3'd0: diff = 17'(tx_q[leg_q]);
        3'd1: diff = 17'(ty_q[leg_q]) - 17'(cfg.home_y);
        3'd2: diff = 17'(tz_q[leg_q]) - 17'(cfg.home_z);
        default: diff = '0;
      endcase
      case (st_q)
        3'd1: begin
          wr_x = 1'b1;
          nx   = sat16(dec);
        end
        3'd2: begin
          wr_y = 1'b1;
          ny   = sat16(48'(cfg.home_y) + dec);
        end
        3'd3: begin
          wr_z = 1'b1;
          nz   = sat16(48'(cfg.home_z) + dec);
          last_step = 1'b1;
        end
        default: ;
      endcase
      neg_d = diff[16];
      mag   = diff[16] ? -18'(diff) : 18'(diff);
      mul_a = 30'(mag);
      mul_b = 18'sd62259;
    end
    if (state_q != S_MUL) begin
      wr_x = 1'b0;
      wr_y = 1'b0;
      wr_z = 1'b0;
      last_step = 1'b0;
    end
  end

  assign prod_d = 48'(mul_a) * 48'(mul_b);

  // sequencer
  always_comb begin
    state_d = state_q;
    leg_d   = leg_q;
    st_d    = st_q;
    load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          leg_d   = '0;
          st_d    = '0;
          state_d = nonzero ? S_DIV : S_MUL;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_MUL;
      end
      S_MUL: begin
        st_d = st_q + 3'd1;
        if (last_step) begin
          st_d = '0;
          if (leg_q == LEG_W'(LEG_COUNT - 1)) begin
            leg_d   = '0;
            state_d = S_EMIT;
          end else begin
            leg_d = leg_q + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (!ov_q || out_ready_i) begin
          load  = 1'b1;
          leg_d = leg_q + 1'b1;
          if (leg_q == LEG_W'(LEG_COUNT - 1)) begin
            leg_d   = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ov_d = load | (ov_q & !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      running_q <= 1'b0;
      start_q   <= '0;
      leg_q     <= '0;
      st_q      <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      start_q   <= start_d;
      leg_q     <= leg_d;
      st_q      <= st_d;
      ov_q      <= ov_d;
    end
  end

  // stored leg targets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEG_COUNT; i++) begin
        tx_q[i] <= RST_HOME_X;
        ty_q[i] <= RST_HOME_Y;
        tz_q[i] <= RST_HOME_Z;
      end
    end else begin
      if (wr_x) tx_q[leg_q] <= nx;
      if (wr_y) ty_q[leg_q] <= ny;
      if (wr_z) tz_q[leg_q] <= nz;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
    if (accept) begin
      mx_q <= clamp_move(move_x_i);
      my_q <= clamp_move(move_y_i);
    end
    if (div_done) phase_q <= div_phase;
    if (load) begin
      oleg_q  <= leg_q;
      ox_q    <= tx_q[leg_q];
      oy_q    <= ty_q[leg_q];
      oz_q    <= tz_q[leg_q];
      owalk_q <= running_q;
    end
  end

  assign out_valid_o = ov_q;
  assign leg_index_o = oleg_q;
  assign target_x_o  = ox_q;
  assign target_y_o  = oy_q;
  assign target_z_o  = oz_q;
  assign walking_o   = owalk_q;
  assign last_leg_o  = (oleg_q == LEG_W'(LEG_COUNT - 1));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   leg_q <= LEG_W'(LEG_COUNT - 1))
    else $error("leg counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   load |-> (!ov_q || out_ready_i))
    else $error("output overwritten while held");

endmodule
